// ===== design/vdei_pkg.sv =====
// Shared types for the vertex dedup indexer: packed vertex word and result.
// No dependencies.
package vdei_pkg;

    localparam int WORD_W   = 32;
    localparam int VERTEX_W = 8 * WORD_W;
    localparam int INDEX_W  = 8;

    // First declared member sits in the highest bits, so pos_x lands in [31:0].
    typedef struct packed {
        logic [WORD_W-1:0] norm_z;
        logic [WORD_W-1:0] norm_y;
        logic [WORD_W-1:0] norm_x;
        logic [WORD_W-1:0] tex_v;
        logic [WORD_W-1:0] tex_u;
        logic [WORD_W-1:0] pos_z;
        logic [WORD_W-1:0] pos_y;
        logic [WORD_W-1:0] pos_x;
    } vertex_t;

    typedef struct packed {
        logic               overflow;
        logic               is_new;
        logic [INDEX_W-1:0] vertex_index;
    } result_t;

endpackage

// ===== design/vdei_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vdei_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wen,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             ren,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/vdei_seq.sv =====
// Scan sequencer: walks the vertex table one entry a cycle through the shared
// 256-bit comparator, resolves hit, append or overflow. Depends on vdei_pkg.
module vdei_seq #(
    parameter int TABLE_DEPTH = 256,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input transaction
    input  logic                       in_valid,
    output logic                       in_ready,
    input  vdei_pkg::vertex_t          in_vertex,
    input  logic                       in_last,
    // table memory
    output logic                       mem_ren,
    output logic [AW-1:0]              mem_raddr,
    input  logic [vdei_pkg::VERTEX_W-1:0] mem_rdata,
    output logic                       mem_wen,
    output logic [AW-1:0]              mem_waddr,
    output logic [vdei_pkg::VERTEX_W-1:0] mem_wdata,
    // result
    output logic                       res_valid,
    input  logic                       res_ready,
    output vdei_pkg::result_t          res
);

    import vdei_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t          state_reg;
    vertex_t         vtx_reg;
    logic            last_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   rd_idx_reg;
    logic            cmp_valid_reg;
    logic [AW-1:0]   cmp_idx_reg;
    result_t         res_reg;

    logic            issue;
    logic            hit;
    logic            room;

    function automatic logic [INDEX_W-1:0] to_index(input logic [AW-1:0] a);
        logic [XW-1:0] w;
        w = XW'(a);
        return w[INDEX_W-1:0];
    endfunction

    assign issue = (rd_idx_reg < count_reg);
    assign hit   = cmp_valid_reg && (vertex_t'(mem_rdata) == vtx_reg);
    assign room  = (count_reg < CW'(TABLE_DEPTH));

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    assign mem_ren   = (state_reg == S_SCAN) && issue;
    assign mem_raddr = rd_idx_reg[AW-1:0];
    assign mem_wen   = (state_reg == S_SCAN) && !hit && !issue && room;
    assign mem_waddr = count_reg[AW-1:0];
    assign mem_wdata = vtx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vtx_reg       <= '0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            res_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        vtx_reg       <= in_vertex;
                        last_reg      <= in_last;
                        rd_idx_reg    <= '0;
                        cmp_valid_reg <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        res_reg   <= '{overflow: 1'b0, is_new: 1'b0,
                                       vertex_index: to_index(cmp_idx_reg)};
                        if (last_reg)
                        begin
                            count_reg <= '0;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (!issue)
                    begin
                        // every stored entry compared without a match
                        if (room)
                        begin
                            res_reg   <= '{overflow: 1'b0, is_new: 1'b1,
                                           vertex_index: to_index(count_reg[AW-1:0])};
                            count_reg <= last_reg ? '0 : count_reg + 1'b1;
                        end
                        else
                        begin
                            res_reg <= '{overflow: 1'b1, is_new: 1'b0, vertex_index: '0};
                            if (last_reg)
                            begin
                                count_reg <= '0;
                            end
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        rd_idx_reg    <= rd_idx_reg + 1'b1;
                        cmp_valid_reg <= 1'b1;
                        cmp_idx_reg   <= rd_idx_reg[AW-1:0];
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/vertex_dedup_exact_indexer.sv =====
// Top level of the exact-match vertex dedup indexer: table RAM, scan
// sequencer and output register. Depends on vdei_pkg, vdei_ram, vdei_seq.
//
// Usage:
//   Slave stream s_axis carries one vertex per transaction: eight raw 32-bit
//   float words in tdata, tlast marks the last vertex of a mesh. Master
//   stream m_axis returns exactly one result per vertex: the 8-bit index in
//   tdata, is_new and overflow flags in tuser.
//   Each vertex is compared bitwise against the stored entries, one entry per
//   cycle from index 0, through a single 256-bit comparator fed by the table
//   RAM's one read port. The search stops at the first match.
//   s_axis_tready is low while a search runs.
//   A miss with room appends the vertex and sets is_new; a miss with a full
//   table returns index 0 with overflow set. After a tlast vertex the table
//   empties, so the next mesh starts at index 0.
//   Reset empties the table at once; RAM contents are not cleared since only
//   entries below the fill count are ever read.
//   A stalled m_axis holds the result in the output register; the sequencer
//   keeps its finished result until that register frees, then takes input.
module vertex_dedup_exact_indexer #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z (32 bits each)
    input  logic [255:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vertex_index
    output logic [7:0]   m_axis_tdata,
    // is_new, overflow
    output logic [1:0]   m_axis_tuser
);

    import vdei_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                mem_ren;
    logic [AW-1:0]       mem_raddr;
    logic [VERTEX_W-1:0] mem_rdata;
    logic                mem_wen;
    logic [AW-1:0]       mem_waddr;
    logic [VERTEX_W-1:0] mem_wdata;

    logic                res_valid;
    logic                res_ready;
    result_t             res;

    logic                out_valid_reg;
    result_t             out_res_reg;

    vdei_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .wen   (mem_wen),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .ren   (mem_ren),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    vdei_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_vertex (vertex_t'(s_axis_tdata)),
        .in_last   (s_axis_tlast),
        .mem_ren   (mem_ren),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_wen   (mem_wen),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
                out_res_reg   <= res;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.vertex_index;
    assign m_axis_tuser  = {out_res_reg.overflow, out_res_reg.is_new};

    // a result is never both appended and overflowed
    a_new_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("is_new and overflow both set");

    a_ovf_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 8'd0))
        else $error("overflow result with nonzero index");

    // input ready is low in the cycle after a vertex is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after accept");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && out_valid_reg && !m_axis_tready) |=> res_valid)
        else $error("result dropped while output stalled");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for vertex_dedup_exact_indexer: directed table, then random meshes.
// Checked against typed rows or an in-bench table of distinct vertices. Depends on vdei_pkg.
`timescale 1ns / 100ps

module tb_top;
    import vdei_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;
    localparam int MAX_SHOWN    = 10;
    localparam int RANDOM_ITEMS = 1400;
    localparam int FULL_EXTRA   = 12;

    typedef struct {
        vertex_t v;
        bit      last;
        bit      typed;
        result_t res;
    } dir_row_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y, norm_z (32 bits each)
    logic [255:0] s_axis_tdata  = '0;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // vertex_index
    logic [7:0]   m_axis_tdata;
    // is_new, overflow
    logic [1:0]   m_axis_tuser;

    // Shadow of the block's table of distinct vertices
    vertex_t     seen_tbl [TABLE_DEPTH];
    int unsigned seen_cnt = 0;
    result_t     pending_results [$];

    int mismatches   = 0;
    int n_hit        = 0;
    int n_new        = 0;
    int n_ovf        = 0;
    int n_sent       = 0;
    int n_meshes     = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_left    = 0;

    vertex_dedup_exact_indexer #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Search, append or overflow, then clear on end of mesh
    function automatic result_t lookup_vertex(input vertex_t v, input bit last);
        result_t r;
        bit      hit;
        r   = '0;
        hit = 1'b0;
        for (int unsigned i = 0; i < seen_cnt; i++)
        begin
            if (!hit && seen_tbl[i] == v)
            begin
                r.vertex_index = i[7:0];
                hit = 1'b1;
            end
        end
        if (!hit)
        begin
            if (seen_cnt < TABLE_DEPTH)
            begin
                seen_tbl[seen_cnt] = v;
                r.vertex_index     = seen_cnt[7:0];
                r.is_new           = 1'b1;
                seen_cnt++;
            end
            else
            begin
                r.overflow = 1'b1;
            end
        end
        if (last)
            seen_cnt = 0;
        return r;
    endfunction

    function automatic dir_row_t dir_row(input vertex_t v, input bit last, input bit typed,
                                         input int idx, input bit nw, input bit ov);
        dir_row_t r;
        r.v                = v;
        r.last             = last;
        r.typed            = typed;
        r.res.vertex_index = idx[7:0];
        r.res.is_new       = nw;
        r.res.overflow     = ov;
        return r;
    endfunction

    function automatic vertex_t fresh_vertex();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Mostly repeats of stored vertices, one-bit near misses and float corner patterns
    function automatic vertex_t mesh_vertex();
        logic [255:0] bits;
        logic [31:0]  sp;
        int           sel;
        int           bpos;
        sel = $urandom_range(99);
        if (seen_cnt != 0 && sel < 40)
            return seen_tbl[$urandom_range(seen_cnt - 1)];
        if (seen_cnt != 0 && sel < 55)
        begin
            bits = seen_tbl[$urandom_range(seen_cnt - 1)];
            bpos = $urandom_range(255);
            bits[bpos] = ~bits[bpos];
            return bits;
        end
        if (sel < 67)
        begin
            case ($urandom_range(5))
                0:       sp = 32'h0000_0000;
                1:       sp = 32'h8000_0000;
                2:       sp = 32'h7F80_0000;
                3:       sp = 32'h7FC0_0000;
                4:       sp = 32'h7FC0_0001;
                default: sp = 32'hFFFF_FFFF;
            endcase
            bits = {8{sp}};
            // sign flip on pos_x: +0/-0 and NaN sign variants
            if ($urandom_range(1) == 1)
                bits[31] = ~bits[31];
            return bits;
        end
        return fresh_vertex();
    endfunction

    task automatic set_phase(input int p);
        case (p % 4)
            0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1:       begin tx_idle_pct = 72; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 72; end
            default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
        endcase
    endtask

    task automatic offer(input vertex_t v, input bit last, input bit typed,
                         input result_t res);
        result_t pred;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = lookup_vertex(v, last);
        pending_results.insert(pending_results.size(), typed ? res : pred);
        n_sent++;
    endtask

    task automatic drain_expected();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (pending_results.size() != 0 && guard < 200000);
    endtask

    task automatic run_mesh(input int len, input bit full);
        vertex_t v;
        bit      last;
        for (int k = 0; k < len; k++)
        begin
            last = (k == len - 1) || (!full && $urandom_range(99) < 3);
            if (!full)
                v = mesh_vertex();
            else if (k < TABLE_DEPTH || k == len - 1)
                v = fresh_vertex();
            else if (k == TABLE_DEPTH)
                v = seen_tbl[0];
            else if (k == TABLE_DEPTH + 1)
                v = seen_tbl[TABLE_DEPTH - 1];
            else
            begin
                case ($urandom_range(2))
                    0:       v = fresh_vertex();
                    1:       v = seen_tbl[$urandom_range(TABLE_DEPTH - 1)];
                    default: v = seen_tbl[TABLE_DEPTH - 1];
                endcase
            end
            offer(v, last, 1'b0, '0);
        end
    endtask

    function automatic void note_mismatch(input string msg);
        if (mismatches < MAX_SHOWN)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endfunction

    // Output receiver: random stalls plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (m_axis_tuser[1])
                n_ovf++;
            else if (m_axis_tuser[0])
                n_new++;
            else
                n_hit++;
            if (pending_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result idx=%0d new=%0b ovf=%0b",
                                        m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]));
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.vertex_index || m_axis_tuser[0] !== want.is_new ||
                    m_axis_tuser[1] !== want.overflow)
                    note_mismatch($sformatf(
                        "exp idx=%0d new=%0b ovf=%0b, got idx=%0d new=%0b ovf=%0b",
                        want.vertex_index, want.is_new, want.overflow,
                        m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]));
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t rows [$];
        vertex_t  v_zero;
        vertex_t  v_ones;
        vertex_t  v_neg0;
        vertex_t  v_nan_a;
        vertex_t  v_nan_b;
        vertex_t  v_inf;
        vertex_t  v_near;
        vertex_t  v_r1;
        vertex_t  v_r2;
        int       rand_items;
        int       len;

        v_zero         = '0;
        v_ones         = '1;
        v_neg0         = '0;
        v_neg0.pos_x   = 32'h8000_0000;
        v_nan_a        = {8{32'h7FC0_0000}};
        v_nan_b        = v_nan_a;
        v_nan_b.norm_z = 32'h7FC0_0001;
        v_inf          = {8{32'h7F80_0000}};
        v_near         = v_ones;
        v_near.norm_z  = 32'hFFFF_FFFE;
        v_r1           = fresh_vertex();
        v_r2           = fresh_vertex();

        rows.insert(rows.size(), dir_row(v_zero,  1'b0, 1'b1, 0, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row(v_ones,  1'b0, 1'b1, 1, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row(v_zero,  1'b0, 1'b1, 0, 1'b0, 1'b0));
        rows.insert(rows.size(), dir_row(v_neg0,  1'b0, 1'b1, 2, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row(v_nan_a, 1'b0, 1'b1, 3, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row(v_nan_a, 1'b0, 1'b1, 3, 1'b0, 1'b0));
        rows.insert(rows.size(), dir_row(v_nan_b, 1'b0, 1'b1, 4, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row({8{32'hAAAA_AAAA}}, 1'b0, 1'b1, 5, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row({8{32'h5555_5555}}, 1'b0, 1'b1, 6, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row(v_ones,  1'b0, 1'b1, 1, 1'b0, 1'b0));
        rows.insert(rows.size(), dir_row(v_inf,   1'b0, 1'b1, 7, 1'b1, 1'b0));
        // hit on end of mesh, then the table starts over
        rows.insert(rows.size(), dir_row(v_neg0,  1'b1, 1'b1, 2, 1'b0, 1'b0));
        rows.insert(rows.size(), dir_row(v_neg0,  1'b0, 1'b1, 0, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row(v_zero,  1'b1, 1'b1, 1, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row(v_ones,  1'b1, 1'b1, 0, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row(v_ones,  1'b0, 1'b1, 0, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row(v_near,  1'b0, 1'b1, 1, 1'b1, 1'b0));
        rows.insert(rows.size(), dir_row(v_r1,    1'b0, 1'b0, 0, 1'b0, 1'b0));
        rows.insert(rows.size(), dir_row(v_r2,    1'b0, 1'b0, 0, 1'b0, 1'b0));
        rows.insert(rows.size(), dir_row(v_r1,    1'b0, 1'b0, 0, 1'b0, 1'b0));
        rows.insert(rows.size(), dir_row(v_r2,    1'b1, 1'b0, 0, 1'b0, 1'b0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_phase(0);
        foreach (rows[i])
            offer(rows[i].v, rows[i].last, rows[i].typed, rows[i].res);

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            set_phase(n_meshes);
            if (n_meshes % 9 == 4)
                drain_expected();
            if (n_meshes == 1 || n_meshes == 22)
            begin
                len = TABLE_DEPTH + FULL_EXTRA;
                run_mesh(len, 1'b1);
            end
            else
            begin
                if (n_meshes == 6 || n_meshes == 30)
                begin
                    // output held off while input keeps coming
                    hold_req = 600;
                    len = 40;
                end
                else if ($urandom_range(99) < 70)
                    len = $urandom_range(24, 1);
                else if ($urandom_range(99) < 83)
                    len = $urandom_range(90, 25);
                else
                    len = $urandom_range(200, 91);
                run_mesh(len, 1'b0);
            end
            rand_items += len;
            n_meshes++;
        end

        drain_expected();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end

        $display("Sent %0d vertices, %0d random meshes: %0d hits, %0d appends, %0d overflows",
                 n_sent, n_meshes, n_hit, n_new, n_ovf);
        $display("Idle mixes, two full tables, two long output hold-offs; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
